// ----- design/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg: shared definitions for the quaternion vector rotator
// Default widths and the pipeline enable bundle shared by the datapath units.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	localparam int MAT_TERMS = 9;
	localparam int ROW_TERMS = 3;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic out;
	} pipe_en_t;

endpackage

// ----- design/qvr_matrix.sv -----
// ----------------------------------------------------------------------------
// qvr_matrix: rotation matrix generator
// Stage 1 forms the nine quaternion products, stage 2 rounds them, builds the
// nine matrix terms and clips each to the data width.
// ----------------------------------------------------------------------------
module qvr_matrix #(
	parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qvr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  qvr_pkg::pipe_en_t            en,
	input  logic signed [DATA_WIDTH-1:0] quat_r,
	input  logic signed [DATA_WIDTH-1:0] quat_i,
	input  logic signed [DATA_WIDTH-1:0] quat_j,
	input  logic signed [DATA_WIDTH-1:0] quat_k,
	output logic signed [DATA_WIDTH-1:0] term_s2 [qvr_pkg::MAT_TERMS],
	output logic                         sat_s2
);
	import qvr_pkg::*;

	localparam int PW = 2 * DATA_WIDTH;
	localparam int QW = 2 * DATA_WIDTH + 3;
	localparam logic signed [QW-1:0] HALF = QW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QW-1:0] ONE  = QW'(1) <<< FRAC_BITS;
	localparam logic signed [QW-1:0] SMAX = (QW'(1) <<< (DATA_WIDTH - 1)) - QW'(1);
	localparam logic signed [QW-1:0] SMIN = -SMAX - QW'(1);

	localparam int II = 0;
	localparam int JJ = 1;
	localparam int KK = 2;
	localparam int IJ = 3;
	localparam int IK = 4;
	localparam int JK = 5;
	localparam int IR = 6;
	localparam int JR = 7;
	localparam int KR = 8;

	logic signed [PW-1:0]         prod_s1 [MAT_TERMS];
	logic signed [QW-1:0]         rp      [MAT_TERMS];
	logic signed [QW-1:0]         raw     [MAT_TERMS];
	logic signed [DATA_WIDTH-1:0] term    [MAT_TERMS];
	logic [MAT_TERMS-1:0]         clip_hit;

	function automatic logic signed [QW-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [QW-1:0] t;
		t = QW'(p) + HALF;
		return t >>> FRAC_BITS;
	endfunction

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1[II] <= quat_i * quat_i;
			prod_s1[JJ] <= quat_j * quat_j;
			prod_s1[KK] <= quat_k * quat_k;
			prod_s1[IJ] <= quat_i * quat_j;
			prod_s1[IK] <= quat_i * quat_k;
			prod_s1[JK] <= quat_j * quat_k;
			prod_s1[IR] <= quat_i * quat_r;
			prod_s1[JR] <= quat_j * quat_r;
			prod_s1[KR] <= quat_k * quat_r;
		end
	end

	always_comb begin
		for (int n = 0; n < MAT_TERMS; n++) begin
			rp[n] = rnd(prod_s1[n]);
		end
		raw[0] = ONE - ((rp[JJ] + rp[KK]) <<< 1);
		raw[1] = (rp[IJ] - rp[KR]) <<< 1;
		raw[2] = (rp[IK] + rp[JR]) <<< 1;
		raw[3] = (rp[IJ] + rp[KR]) <<< 1;
		raw[4] = ONE - ((rp[II] + rp[KK]) <<< 1);
		raw[5] = (rp[JK] - rp[IR]) <<< 1;
		raw[6] = (rp[IK] - rp[JR]) <<< 1;
		raw[7] = (rp[JK] + rp[IR]) <<< 1;
		raw[8] = ONE - ((rp[II] + rp[JJ]) <<< 1);
		for (int n = 0; n < MAT_TERMS; n++) begin
			if (raw[n] > SMAX) begin
				term[n]     = SMAX[DATA_WIDTH-1:0];
				clip_hit[n] = 1'b1;
			end else if (raw[n] < SMIN) begin
				term[n]     = SMIN[DATA_WIDTH-1:0];
				clip_hit[n] = 1'b1;
			end else begin
				term[n]     = raw[n][DATA_WIDTH-1:0];
				clip_hit[n] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			term_s2 <= term;
			sat_s2  <= |clip_hit;
		end
	end

endmodule

// ----- design/qvr_lane.sv -----
// ----------------------------------------------------------------------------
// qvr_lane: one output row of the rotation
// Multiplies a matrix row by the vector, then rounds, sums and clips the row.
// ----------------------------------------------------------------------------
module qvr_lane #(
	parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qvr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  qvr_pkg::pipe_en_t            en,
	input  logic signed [DATA_WIDTH-1:0] row   [qvr_pkg::ROW_TERMS],
	input  logic signed [DATA_WIDTH-1:0] vec   [qvr_pkg::ROW_TERMS],
	output logic signed [DATA_WIDTH-1:0] sum,
	output logic                         sat
);
	import qvr_pkg::*;

	localparam int PW = 2 * DATA_WIDTH;
	localparam int QW = 2 * DATA_WIDTH + 3;
	localparam logic signed [QW-1:0] HALF = QW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QW-1:0] SMAX = (QW'(1) <<< (DATA_WIDTH - 1)) - QW'(1);
	localparam logic signed [QW-1:0] SMIN = -SMAX - QW'(1);

	logic signed [PW-1:0] prod_s3 [ROW_TERMS];
	logic signed [QW-1:0] acc;

	function automatic logic signed [QW-1:0] rnd(input logic signed [PW-1:0] p);
		logic signed [QW-1:0] t;
		t = QW'(p) + HALF;
		return t >>> FRAC_BITS;
	endfunction

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int n = 0; n < ROW_TERMS; n++) begin
				prod_s3[n] <= row[n] * vec[n];
			end
		end
	end

	always_comb begin
		acc = rnd(prod_s3[0]) + rnd(prod_s3[1]) + rnd(prod_s3[2]);
		if (acc > SMAX) begin
			sum = SMAX[DATA_WIDTH-1:0];
			sat = 1'b1;
		end else if (acc < SMIN) begin
			sum = SMIN[DATA_WIDTH-1:0];
			sat = 1'b1;
		end else begin
			sum = acc[DATA_WIDTH-1:0];
			sat = 1'b0;
		end
	end

endmodule

// ----- design/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate: rotate a vector by a fixed-point quaternion
// Builds the rotation matrix from the quaternion, three row lanes apply it to
// the vector, and a merge stage registers the result and saturation flag.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | vec_x..z, quat_r..k
//   out     | output    | out_valid / out_ready  | rot_x..z, saturated
//
// One item per cycle sustained while out_ready holds; an input transfer reaches
// out_valid through the four register stages (products, matrix, row products,
// output). Each stage moves when empty or when the next one moves, so bubbles
// close up under a stalled output. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
	parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = qvr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] vec_x,
	input  logic signed [DATA_WIDTH-1:0] vec_y,
	input  logic signed [DATA_WIDTH-1:0] vec_z,
	input  logic signed [DATA_WIDTH-1:0] quat_r,
	input  logic signed [DATA_WIDTH-1:0] quat_i,
	input  logic signed [DATA_WIDTH-1:0] quat_j,
	input  logic signed [DATA_WIDTH-1:0] quat_k,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] rot_x,
	output logic signed [DATA_WIDTH-1:0] rot_y,
	output logic signed [DATA_WIDTH-1:0] rot_z,
	output logic                         saturated
);
	import qvr_pkg::*;

	pipe_en_t en;

	logic v_s1, v_s2, v_s3, out_valid_q;
	logic sat_s2, sat_s3;

	logic signed [DATA_WIDTH-1:0] vec_s1  [ROW_TERMS];
	logic signed [DATA_WIDTH-1:0] vec_s2  [ROW_TERMS];
	logic signed [DATA_WIDTH-1:0] term_s2 [MAT_TERMS];
	logic signed [DATA_WIDTH-1:0] row_x   [ROW_TERMS];
	logic signed [DATA_WIDTH-1:0] row_y   [ROW_TERMS];
	logic signed [DATA_WIDTH-1:0] row_z   [ROW_TERMS];
	logic signed [DATA_WIDTH-1:0] sum_x, sum_y, sum_z;
	logic sat_x, sat_y, sat_z;

	logic signed [DATA_WIDTH-1:0] rot_x_q, rot_y_q, rot_z_q;
	logic                         saturated_q;

	always_comb begin
		en.out = !out_valid_q || out_ready;
		en.s3  = !v_s3 || en.out;
		en.s2  = !v_s2 || en.s3;
		en.s1  = !v_s1 || en.s2;
	end

	assign in_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.s1)  v_s1        <= in_valid;
			if (en.s2)  v_s2        <= v_s1;
			if (en.s3)  v_s3        <= v_s2;
			if (en.out) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			vec_s1[0] <= vec_x;
			vec_s1[1] <= vec_y;
			vec_s1[2] <= vec_z;
		end
		if (en.s2) begin
			vec_s2 <= vec_s1;
		end
		if (en.s3) begin
			sat_s3 <= sat_s2;
		end
	end

	qvr_matrix #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_matrix (
		.clk    (clk),
		.en     (en),
		.quat_r (quat_r),
		.quat_i (quat_i),
		.quat_j (quat_j),
		.quat_k (quat_k),
		.term_s2(term_s2),
		.sat_s2 (sat_s2)
	);

	always_comb begin
		for (int n = 0; n < ROW_TERMS; n++) begin
			row_x[n] = term_s2[n];
			row_y[n] = term_s2[ROW_TERMS + n];
			row_z[n] = term_s2[2 * ROW_TERMS + n];
		end
	end

	qvr_lane #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_lane_x (
		.clk(clk),
		.en (en),
		.row(row_x),
		.vec(vec_s2),
		.sum(sum_x),
		.sat(sat_x)
	);

	qvr_lane #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_lane_y (
		.clk(clk),
		.en (en),
		.row(row_y),
		.vec(vec_s2),
		.sum(sum_y),
		.sat(sat_y)
	);

	qvr_lane #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_lane_z (
		.clk(clk),
		.en (en),
		.row(row_z),
		.vec(vec_s2),
		.sum(sum_z),
		.sat(sat_z)
	);

	always_ff @(posedge clk) begin
		if (en.out) begin
			rot_x_q     <= sum_x;
			rot_y_q     <= sum_y;
			rot_z_q     <= sum_z;
			saturated_q <= sat_s3 | sat_x | sat_y | sat_z;
		end
	end

	assign out_valid = out_valid_q;
	assign rot_x     = rot_x_q;
	assign rot_y     = rot_y_q;
	assign rot_z     = rot_z_q;
	assign saturated = saturated_q;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input not ready while output stage is empty");

	a_s3_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en.out |=> v_s3)
		else $error("row product stage dropped an item under stall");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({rot_x, rot_y, rot_z, saturated}))
		else $error("output changed before transfer");

endmodule
